### sv/imhu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhu_pkg
// shared types and constants for the indexed max-heap update block
// ----------------------------------------------------------------------------
package imhu_pkg;

  localparam int NCatDefault = 64;
  localparam int KeyW = 32;
  localparam int CatW = 6;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [CatW-1:0] cat_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic setk;
    logic rd_own;
    logic rd_key;
    logic swap_a;
    logic swap_b;
    logic rd_root;
    logic rd_rkey;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic skip;
    logic clr_last;
    logic stop;
  } sts_t;

endpackage

### sv/imhu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhu_ctrl
// sequencer for clear sweep and sift steps
// ----------------------------------------------------------------------------
module imhu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output imhu_pkg::cmd_t   cmd,
  input  imhu_pkg::sts_t   sts
);
  import imhu_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_CLR   = 4'd3;
  localparam logic [3:0] S_SETK  = 4'd4;
  localparam logic [3:0] S_RDOWN = 4'd5;
  localparam logic [3:0] S_RDKEY = 4'd6;
  localparam logic [3:0] S_EVAL  = 4'd7;
  localparam logic [3:0] S_SWAP  = 4'd8;
  localparam logic [3:0] S_RDRT  = 4'd9;
  localparam logic [3:0] S_RDRK  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      // sweep after reset, no result
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: if (start) state_next = S_LOAD;
      S_LOAD: begin
        cmd.load = 1'b1;
        if (sts.is_clear) state_next = S_CLR;
        else if (sts.skip) state_next = S_RDRT;
        else state_next = S_SETK;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_RDRT;
      end
      S_SETK: begin
        cmd.setk = 1'b1;
        state_next = S_RDOWN;
      end
      S_RDOWN: begin
        cmd.rd_own = 1'b1;
        state_next = S_RDKEY;
      end
      S_RDKEY: begin
        cmd.rd_key = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.stop) state_next = S_RDRT;
        else begin
          cmd.swap_a = 1'b1;
          state_next = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd.swap_b = 1'b1;
        state_next = S_RDOWN;
      end
      S_RDRT: begin
        cmd.rd_root = 1'b1;
        state_next = S_RDRK;
      end
      S_RDRK: begin
        cmd.rd_rkey = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### sv/imhu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhu_dp
// key store, position maps and sift compare/swap datapath
// ----------------------------------------------------------------------------
module imhu_dp #(
  parameter int NCat = imhu_pkg::NCatDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   op,
  input  logic [5:0]             category,
  input  logic signed [31:0]     new_key,
  input  imhu_pkg::cmd_t         cmd,
  output imhu_pkg::sts_t         sts,
  output logic                   done,
  output logic signed [31:0]     max_key,
  output logic [5:0]             max_category,
  output logic [5:0]             new_position
);
  import imhu_pkg::*;

  localparam int AW = (NCat > 1) ? $clog2(NCat) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LastIdx = CW'(NCat - 1);
  localparam logic [CW-1:0] HalfN = CW'(NCat / 2);
  localparam logic [CW-1:0] HalfM = CW'((NCat - 1) / 2);

  // keys per category, owner per position, position per category
  key_t          keys  [NCat];
  logic [AW-1:0] owner [NCat];
  logic [AW-1:0] cpos  [NCat];

  logic          accept, valid_cat;
  logic          op_r, skip_r, dir_up;
  logic [AW-1:0] cat_r;
  key_t          kc;
  logic [CW-1:0] clr_cnt;
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] pos, other_pos;
  logic [AW-1:0] own_a, own_b;
  key_t          key_a, key_b;
  logic [AW-1:0] own_addr_a, key_addr_a;
  logic          stop_c;
  logic [AW-1:0] pick_cat, pick_pos;
  logic [CW-1:0] pos_w, lpos, rpos, ppos;

  assign accept = start && !busy;
  assign valid_cat = ({26'd0, category} < 32'(NCat));
  assign clr_idx = clr_cnt[AW-1:0];
  assign pos_w = {1'b0, pos};
  assign lpos = (pos_w << 1) + CW'(1);
  assign rpos = (pos_w << 1) + CW'(2);
  assign ppos = (pos_w - CW'(1)) >> 1;
  assign own_addr_a = cmd.rd_root ? '0 : (dir_up ? ppos[AW-1:0] : lpos[AW-1:0]);
  assign key_addr_a = cmd.load ? cat_r : own_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (accept) clr_cnt <= '0;
      else if (cmd.clr_step) clr_cnt <= clr_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= (op == OP_CLEAR);
      skip_r <= (op != OP_CLEAR) && !valid_cat;
      cat_r <= AW'(category);
      kc <= new_key;
    end
    if (cmd.setk) dir_up <= (key_a <= kc);
  end

  // key store
  always_ff @(posedge clk) begin
    if (cmd.clr_step) keys[clr_idx] <= '0;
    else if (cmd.setk) keys[cat_r] <= kc;
    if (cmd.load || cmd.rd_key || cmd.rd_rkey) key_a <= keys[key_addr_a];
    if (cmd.rd_key) key_b <= keys[own_b];
  end

  // owner per heap position
  always_ff @(posedge clk) begin
    if (cmd.clr_step) owner[clr_idx] <= clr_idx;
    else if (cmd.swap_a) owner[pos] <= pick_cat;
    else if (cmd.swap_b) owner[other_pos] <= cat_r;
    if (cmd.rd_own || cmd.rd_root) own_a <= owner[own_addr_a];
    if (cmd.rd_own) own_b <= owner[rpos[AW-1:0]];
  end

  // heap position per category
  always_ff @(posedge clk) begin
    if (cmd.clr_step) cpos[clr_idx] <= clr_idx;
    else if (cmd.swap_a) cpos[pick_cat] <= pos;
    else if (cmd.swap_b) cpos[cat_r] <= other_pos;
    if (cmd.load) pos <= cpos[cat_r];
    else if (cmd.swap_b) pos <= other_pos;
    if (cmd.swap_a) other_pos <= pick_pos;
  end

  always_comb begin
    pick_cat = own_a;
    pick_pos = ppos[AW-1:0];
    stop_c = 1'b0;
    if (dir_up) begin
      if (pos == '0 || kc <= key_a) stop_c = 1'b1;
    end else begin
      pick_pos = lpos[AW-1:0];
      if (pos_w >= HalfN) stop_c = 1'b1;
      else if (pos_w < HalfM && key_a <= key_b) begin
        pick_cat = own_b;
        pick_pos = rpos[AW-1:0];
        if (key_b <= kc) stop_c = 1'b1;
      end else if (key_a <= kc) stop_c = 1'b1;
    end
  end

  assign sts.is_clear = op_r;
  assign sts.skip = skip_r;
  assign sts.clr_last = (clr_cnt == LastIdx);
  assign sts.stop = stop_c;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      max_key <= key_a;
      max_category <= 6'(own_a);
      new_position <= (op_r || skip_r) ? 6'd0 : 6'(pos);
    end
  end

endmodule

### sv/indexed_max_heap_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_max_heap_update
// indexed binary max-heap, one key update or clear per command
// ----------------------------------------------------------------------------
// channel   | handshake            | beat
// command   | start / busy         | op, category, new_key
// result    | done strobe (1 cyc)  | max_key, max_category, new_position
// a set walks the sift loop (read owners, read keys, evaluate, swap) once
// per swap, at most log2(N) swaps, before reading back the root.
// a clear sweeps the maps one entry a cycle; an out-of-range category
// changes nothing and goes straight to reading back the root.
// done comes in the cycle busy falls; the receiver cannot stall it.
// rst is synchronous; the maps are swept after reset with busy high.
module indexed_max_heap_update #(
  parameter int NCat = imhu_pkg::NCatDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [5:0]         category,
  input  logic signed [31:0] new_key,
  output logic               done,
  output logic signed [31:0] max_key,
  output logic [5:0]         max_category,
  output logic [5:0]         new_position
);
  import imhu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  imhu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  imhu_dp #(.NCat(NCat)) u_dp (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .category(category), .new_key(new_key), .cmd(cmd), .sts(sts),
    .done(done), .max_key(max_key), .max_category(max_category),
    .new_position(new_position)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives key updates and clears into the indexed max-heap block and checks
// every result against a behavioral heap kept alongside it
// ----------------------------------------------------------------------------
module tb;
  import imhu_pkg::*;

  localparam int NC = 64;

  typedef struct {
    logic op;
    cat_t cat;
    key_t key;
    logic known;
    key_t x_key;
    cat_t x_cat;
    cat_t x_pos;
  } row_t;

  typedef struct {
    key_t mk;
    cat_t mc;
    cat_t np;
  } heap_res_t;

  logic clk, rst, start, busy, op, done;
  logic [5:0] category, max_category, new_position;
  logic signed [31:0] new_key, max_key;

  key_t hkey [NC];
  cat_t howner [NC];
  cat_t hpos [NC];
  heap_res_t pending_q [$];
  int errors;
  int mismatches;
  logic hold_off;
  int quiet_lo, quiet_hi;
  row_t rows [$];

  indexed_max_heap_update dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .category(category), .new_key(new_key), .done(done),
    .max_key(max_key), .max_category(max_category), .new_position(new_position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void heap_clear();
    for (int k = 0; k < NC; k++) begin
      hkey[k] = '0;
      howner[k] = cat_t'(k);
      hpos[k] = cat_t'(k);
    end
  endfunction

  function automatic void swap_cats(cat_t a, cat_t b);
    cat_t pa, pb;
    pa = hpos[a];
    pb = hpos[b];
    howner[pa] = b;
    howner[pb] = a;
    hpos[a] = pb;
    hpos[b] = pa;
  endfunction

  function automatic heap_res_t heap_update(logic o, cat_t c, key_t k);
    heap_res_t r;
    key_t old;
    logic up;
    int p;
    cat_t par, lc, pick;
    if (o == OP_CLEAR) begin
      heap_clear();
      r.np = '0;
    end else begin
      old = hkey[c];
      hkey[c] = k;
      up = (old <= k);
      for (int g = 0; g < NC; g++) begin
        p = hpos[c];
        if (up) begin
          if (p == 0) break;
          par = howner[(p - 1) / 2];
          if (k <= hkey[par]) break;
          swap_cats(c, par);
        end else begin
          if (p >= NC / 2) break;
          lc = howner[2 * p + 1];
          pick = lc;
          if (p < (NC - 1) / 2 && hkey[lc] <= hkey[howner[2 * p + 2]])
            pick = howner[2 * p + 2];
          if (hkey[pick] <= k) break;
          swap_cats(c, pick);
        end
      end
      r.np = hpos[c];
    end
    r.mk = hkey[howner[0]];
    r.mc = howner[0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    heap_res_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result beat");
      end else begin
        e = pending_q.pop_front();
        if (max_key !== e.mk || max_category !== e.mc || new_position !== e.np) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch exp %h/%0d/%0d got %h/%0d/%0d", e.mk, e.mc, e.np,
                     max_key, max_category, new_position);
        end
      end
    end
  end

  function automatic logic gap();
    return (hold_off || (rows.size() >= quiet_lo && rows.size() < quiet_hi)) ? 1'b0
           : ($urandom_range(99) < 10);
  endfunction

  task automatic send(row_t r);
    heap_res_t e;
    while (gap()) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= r.op;
    category <= r.cat;
    new_key <= r.key;
    @(posedge clk);
    while (busy) @(posedge clk);
    e = heap_update(r.op, r.cat, r.key);
    if (r.known && (e.mk !== r.x_key || e.mc !== r.x_cat || e.np !== r.x_pos)) begin
      errors++;
      $display("directed row disagrees with heap model");
    end
    pending_q.push_back(e);
  endtask

  function automatic row_t mk(logic o, cat_t c, key_t k, logic kn = 0,
                              key_t xk = 0, cat_t xc = 0, cat_t xp = 0);
    row_t r;
    r.op = o; r.cat = c; r.key = k; r.known = kn;
    r.x_key = xk; r.x_cat = xc; r.x_pos = xp;
    return r;
  endfunction

  initial begin
    row_t dir [$];
    row_t r;
    int nrand;
    errors = 0;
    mismatches = 0;
    hold_off = 1'b0;
    quiet_lo = -1;
    quiet_hi = -1;
    rst = 1'b1;
    start = 1'b0;
    op = OP_SET;
    category = '0;
    new_key = '0;
    heap_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    dir.push_back(mk(OP_SET, 6'd0, 32'sd0, 1, 32'sd0, 6'd0, 6'd0));
    dir.push_back(mk(OP_SET, 6'd63, 32'sh7fffffff, 1, 32'sh7fffffff, 6'd63, 6'd0));
    dir.push_back(mk(OP_SET, 6'd5, 32'sh7fffffff));
    dir.push_back(mk(OP_SET, 6'd63, 32'sh80000000));
    dir.push_back(mk(OP_SET, 6'd5, 32'sh80000000));
    dir.push_back(mk(OP_SET, 6'd20, 32'sh00010000));
    dir.push_back(mk(OP_SET, 6'd20, 32'sh00010000));
    dir.push_back(mk(OP_SET, 6'd40, 32'shffff0000));
    dir.push_back(mk(OP_SET, 6'd31, 32'sh00008000));
    dir.push_back(mk(OP_SET, 6'd32, 32'sh00008000));
    dir.push_back(mk(OP_CLEAR, 6'd63, 32'sh7fffffff, 1, 32'sd0, 6'd0, 6'd0));
    dir.push_back(mk(OP_SET, 6'd62, 32'shffffffff));
    dir.push_back(mk(OP_SET, 6'd1, 32'sh00000001));
    dir.push_back(mk(OP_SET, 6'd2, 32'sh00000001));
    dir.push_back(mk(OP_SET, 6'd1, 32'sh80000000));
    dir.push_back(mk(OP_CLEAR, 6'd0, 32'sd0, 1, 32'sd0, 6'd0, 6'd0));

    nrand = 450;
    quiet_lo = 150;
    quiet_hi = 230;
    for (int i = 0; i < nrand; i++) begin
      case ($urandom_range(9))
        0: r = mk(OP_SET, cat_t'($urandom_range(63)),
                  ($urandom_range(1) ? 32'sh7fffffff : 32'sh80000000));
        1: r = mk(OP_SET, cat_t'($urandom_range(63)), key_t'($urandom()));
        2, 3: r = mk(OP_SET, cat_t'($urandom_range(63)),
                     key_t'($signed($urandom_range(8)) - 4) <<< 16);
        default: r = mk(($urandom_range(60) == 0) ? OP_CLEAR : OP_SET,
                        cat_t'($urandom_range(63)),
                        key_t'($signed($urandom_range(2000)) - 1000) <<< 12);
      endcase
      rows.push_back(r);
    end

    foreach (dir[i]) send(dir[i]);
    for (int i = 0; i < nrand; i++) begin
      if (i == 300) begin
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      r = rows.pop_front();
      send(r);
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
sv/imhu_pkg.sv
sv/imhu_ctrl.sv
sv/imhu_dp.sv
sv/indexed_max_heap_update.sv
sim/tb.sv
